/* hw/rtl/window_disparity_depth_stats_top_macros.svh */
// Assertion macros shared by the window disparity depth stats RTL
`ifndef WINDOW_DISPARITY_DEPTH_STATS_TOP_MACROS_SVH
`define WINDOW_DISPARITY_DEPTH_STATS_TOP_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define WDDS_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define WDDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wdds_pkg.sv */
// Package: types, constants and command/status structs for the depth stats block
`timescale 1ns / 1ps

package wdds_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int MIN_VALID   = 8;
    localparam int DISP_W      = 12;
    localparam int SUM_W       = 18;
    localparam int SQ_W        = 30;
    localparam int DIV_W       = 37;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
    localparam int ROOT_W      = 38;
    localparam int ROOT_STEPS  = ROOT_W / 2;
    localparam int ROOT_CNT_W  = $clog2(ROOT_STEPS + 1);
    localparam int CFG_W       = 20;
    localparam int BASE_W      = 20;
    localparam int FOCAL_W     = 16;
    localparam int DEPTH_W     = 16;
    localparam int DEPTH_SCALE = 1000;
    localparam int DENOM_W     = 22;

    localparam logic CFG_BASELINE = 1'b0;
    localparam logic CFG_FOCAL    = 1'b1;

    typedef struct packed {
        logic signed [12:0] disparity;
        logic               mask_valid;
        logic [11:0]        point_col;
        logic [11:0]        point_row;
        logic               last_sample;
    } sample_t;

    typedef struct packed {
        logic        status;
        logic [11:0] median_disp;
        logic [15:0] depth_mm;
        logic [11:0] std_disp;
        logic [6:0]  valid_count;
        logic [6:0]  total_count;
        logic [11:0] point_col_out;
        logic [11:0] point_row_out;
    } result_t;

    typedef struct packed {
        logic load_sample;
        logic mul_stats;
        logic form_spread;
        logic div_var_go;
        logic root_go;
        logic med_rd;
        logic med_cand;
        logic sweep;
        logic med_test;
        logic mul_depth;
        logic div_depth_go;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic too_few;
        logic div_done;
        logic root_done;
        logic sweep_done;
        logic found;
    } stat_t;

endpackage

/* hw/rtl/window_disparity_depth_stats_top.sv */
// Top level: window disparity statistics and depth from median disparity
//
// Channel   Direction  Handshake                 Payload
// sample    in         start & !busy             sample_t
// result    out        done (one cycle strobe)   result_t
// config    in         cfg_we                    cfg_idx, cfg_data
//
// Samples are loaded as they are taken and may follow at once; busy stays low
// between samples of a window. After the final sample come a variance divide
// and a square root, a median search over the n valid samples (one store read
// per cycle) and a depth divide; all are skipped when too few are valid.
// Reset clears tallies, config and the controller; the store is not cleared.
// done pulses for one cycle as busy falls; results cannot be stalled.
`timescale 1ns / 1ps

module window_disparity_depth_stats_top
    import wdds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sample_t          sample,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [CFG_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    wdds_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_sample (sample.last_sample),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done)
    );

    wdds_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .sample   (sample),
        .cmd      (cmd),
        .stat     (stat),
        .result   (result)
    );

endmodule

/* hw/rtl/wdds_div.sv */
// Iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wdds_div
    import wdds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 active_reg;
    logic                 done_reg;
    logic [DIV_W:0]       shifted;
    logic                 ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = ge ? DIV_W'(shifted - {1'b0, dvs_reg}) : shifted[DIV_W-1:0];
        quo_next = {quo_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= DIV_CNT_W'(DIV_W);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* hw/rtl/wdds_dp.sv */
// Datapath: sample store, window sums, median search, root and depth
`timescale 1ns / 1ps
`include "window_disparity_depth_stats_top_macros.svh"

module wdds_dp
    import wdds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [CFG_W-1:0] cfg_data,
    input  sample_t          sample,
    input  cmd_t             cmd,
    output stat_t            stat,
    output result_t          result
);

    logic [DISP_W-1:0]  mem [MAX_SAMPLES];
    logic [DISP_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;

    logic [BASE_W-1:0]  baseline_reg;
    logic [FOCAL_W-1:0] focal_reg;
    logic [CNT_W-1:0]   valid_tally_reg;
    logic [CNT_W-1:0]   total_tally_reg;
    logic [SUM_W-1:0]   disp_sum_reg;
    logic [SQ_W-1:0]    disp_sq_reg;

    logic [CNT_W-1:0]   i_reg, j_reg, below_reg, nab_reg;
    logic               pend_reg;
    logic [DISP_W-1:0]  cand_reg, median_reg;
    logic [11:0]        col_reg, row_reg;

    logic [DIV_W-1:0]   prod_a_reg;
    logic [2*SUM_W-1:0] prod_b_reg;
    logic [DIV_W-1:0]   spread_reg;
    logic [2*CNT_W-1:0] nn_reg;
    logic [BASE_W+FOCAL_W-1:0] numer_reg;
    logic [DENOM_W-1:0] denom_reg;

    logic [ROOT_W-1:0]     rv_reg, rr_reg, rbit_reg, rsum;
    logic [ROOT_CNT_W-1:0] rcnt_reg;

    logic [DISP_W-1:0]  raw;
    logic               sample_ok;
    logic               store_en;
    logic [CNT_W-1:0]   rank;
    logic               div_go;
    logic [DIV_W-1:0]   div_num, div_den, div_q;
    logic               div_done;

    assign raw       = sample.disparity[DISP_W-1:0];
    assign sample_ok = sample.mask_valid && !sample.disparity[12] && (raw != '0);
    assign store_en  = total_tally_reg < CNT_W'(MAX_SAMPLES);
    assign rank      = valid_tally_reg >> 1;
    assign rd_addr   = cmd.sweep ? j_reg[ADDR_W-1:0] : i_reg[ADDR_W-1:0];
    assign rsum      = rr_reg + rbit_reg;

    assign div_go  = cmd.div_var_go || cmd.div_depth_go;
    assign div_num = cmd.div_var_go ? spread_reg : DIV_W'(numer_reg);
    assign div_den = cmd.div_var_go ? DIV_W'(nn_reg) : DIV_W'(denom_reg);

    wdds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample && store_en && sample_ok)
        begin
            mem[valid_tally_reg[ADDR_W-1:0]] <= raw;
        end
        if (cmd.med_rd || cmd.sweep)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg    <= '0;
            focal_reg       <= '0;
            valid_tally_reg <= '0;
            total_tally_reg <= '0;
            disp_sum_reg    <= '0;
            disp_sq_reg     <= '0;
            pend_reg        <= 1'b0;
            rcnt_reg        <= '0;
            i_reg           <= '0;
            j_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_BASELINE: baseline_reg <= cfg_data[BASE_W-1:0];
                    CFG_FOCAL:    focal_reg    <= cfg_data[FOCAL_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.load_sample && store_en)
            begin
                total_tally_reg <= total_tally_reg + 1'b1;
                if (sample_ok)
                begin
                    valid_tally_reg <= valid_tally_reg + 1'b1;
                    disp_sum_reg    <= disp_sum_reg + SUM_W'(raw);
                    disp_sq_reg     <= disp_sq_reg + SQ_W'(raw * raw);
                end
            end
            if (cmd.finish)
            begin
                valid_tally_reg <= '0;
                total_tally_reg <= '0;
                disp_sum_reg    <= '0;
                disp_sq_reg     <= '0;
            end
            if (cmd.root_go)
            begin
                rcnt_reg <= ROOT_CNT_W'(ROOT_STEPS);
                i_reg    <= '0;
            end
            else if (rcnt_reg != '0)
            begin
                rcnt_reg <= rcnt_reg - 1'b1;
            end
            if (cmd.med_cand)
            begin
                j_reg    <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.sweep)
            begin
                if (j_reg < valid_tally_reg)
                begin
                    j_reg    <= j_reg + 1'b1;
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.med_test && !stat.found)
            begin
                i_reg <= i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            col_reg <= sample.point_col;
            row_reg <= sample.point_row;
        end
        if (cmd.mul_stats)
        begin
            prod_a_reg <= DIV_W'(valid_tally_reg * disp_sq_reg);
            prod_b_reg <= (2*SUM_W)'(disp_sum_reg) * (2*SUM_W)'(disp_sum_reg);
        end
        if (cmd.form_spread)
        begin
            spread_reg <= prod_a_reg - DIV_W'(prod_b_reg);
            nn_reg     <= (2*CNT_W)'(valid_tally_reg) * (2*CNT_W)'(valid_tally_reg);
        end
        if (cmd.root_go)
        begin
            rv_reg   <= ROOT_W'(div_q);
            rr_reg   <= '0;
            rbit_reg <= ROOT_W'(1) << (ROOT_W - 2);
        end
        else if (rcnt_reg != '0)
        begin
            if (rv_reg >= rsum)
            begin
                rv_reg <= rv_reg - rsum;
                rr_reg <= (rr_reg >> 1) + rbit_reg;
            end
            else
            begin
                rr_reg <= rr_reg >> 1;
            end
            rbit_reg <= rbit_reg >> 2;
        end
        if (cmd.med_cand)
        begin
            cand_reg  <= rd_data_reg;
            below_reg <= '0;
            nab_reg   <= '0;
        end
        else if (cmd.sweep && pend_reg)
        begin
            below_reg <= below_reg + CNT_W'(rd_data_reg < cand_reg);
            nab_reg   <= nab_reg + CNT_W'(rd_data_reg <= cand_reg);
        end
        if (cmd.med_test && stat.found)
        begin
            median_reg <= cand_reg;
        end
        if (cmd.mul_depth)
        begin
            numer_reg <= (BASE_W+FOCAL_W)'(baseline_reg) * (BASE_W+FOCAL_W)'(focal_reg);
            denom_reg <= DENOM_W'(median_reg * DENOM_W'(DEPTH_SCALE));
        end
        if (cmd.finish)
        begin
            result.status        <= stat.too_few;
            result.valid_count   <= valid_tally_reg;
            result.total_count   <= total_tally_reg;
            result.point_col_out <= col_reg;
            result.point_row_out <= row_reg;
            if (stat.too_few)
            begin
                result.median_disp <= '0;
                result.depth_mm    <= '0;
                result.std_disp    <= '0;
            end
            else
            begin
                result.median_disp <= median_reg;
                result.depth_mm    <= (div_q[DIV_W-1:DEPTH_W] != '0) ? '1
                                                                   : div_q[DEPTH_W-1:0];
                result.std_disp    <= (rr_reg[ROOT_W-1:DISP_W] != '0) ? '1
                                                                   : rr_reg[DISP_W-1:0];
            end
        end
    end

    assign stat.too_few    = valid_tally_reg < CNT_W'(MIN_VALID);
    assign stat.div_done   = div_done;
    assign stat.root_done  = rcnt_reg == '0;
    assign stat.sweep_done = (j_reg == valid_tally_reg) && !pend_reg;
    assign stat.found      = (below_reg <= rank) && (rank < nab_reg);

    `WDDS_ASSERT(a_tally_order, valid_tally_reg <= total_tally_reg, "valid tally above total")
    `WDDS_ASSERT(a_total_bound, total_tally_reg <= CNT_W'(MAX_SAMPLES), "total tally overflow")
    `WDDS_ASSERT_NEXT(a_finish_clear, cmd.finish, total_tally_reg == '0, "window not cleared")

endmodule

/* hw/rtl/wdds_ctrl.sv */
// Controller: sequences sample loading and end-of-window computation
`timescale 1ns / 1ps
`include "window_disparity_depth_stats_top_macros.svh"

module wdds_ctrl
    import wdds_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  last_sample,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_MUL, S_SPREAD, S_DIVV, S_DIVV_W, S_ROOT, S_ROOT_W,
        S_MED_RD, S_MED_CAND, S_MED_SWEEP, S_MED_TEST, S_DMUL, S_DIVD, S_DIVD_W,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_sample = 1'b1;
                    if (last_sample)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:     state_next = stat.too_few ? S_FINISH : S_MUL;
            S_MUL:
            begin
                cmd.mul_stats = 1'b1;
                state_next    = S_SPREAD;
            end
            S_SPREAD:
            begin
                cmd.form_spread = 1'b1;
                state_next      = S_DIVV;
            end
            S_DIVV:
            begin
                cmd.div_var_go = 1'b1;
                state_next     = S_DIVV_W;
            end
            S_DIVV_W:    state_next = stat.div_done ? S_ROOT : S_DIVV_W;
            S_ROOT:
            begin
                cmd.root_go = 1'b1;
                state_next  = S_ROOT_W;
            end
            S_ROOT_W:    state_next = stat.root_done ? S_MED_RD : S_ROOT_W;
            S_MED_RD:
            begin
                cmd.med_rd = 1'b1;
                state_next = S_MED_CAND;
            end
            S_MED_CAND:
            begin
                cmd.med_cand = 1'b1;
                state_next   = S_MED_SWEEP;
            end
            S_MED_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_MED_TEST;
                end
            end
            S_MED_TEST:
            begin
                cmd.med_test = 1'b1;
                state_next   = stat.found ? S_DMUL : S_MED_RD;
            end
            S_DMUL:
            begin
                cmd.mul_depth = 1'b1;
                state_next    = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.div_depth_go = 1'b1;
                state_next       = S_DIVD_W;
            end
            S_DIVD_W:    state_next = stat.div_done ? S_FINISH : S_DIVD_W;
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FINISH);
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;

    `WDDS_ASSERT(a_done_idle, !done_reg || state_reg == S_IDLE, "result strobe while busy")
    `WDDS_ASSERT_NEXT(a_plain_sample, start && !busy && !last_sample, !busy,
        "non-final sample left idle")
    `WDDS_ASSERT(a_div_wait, !stat.div_done || state_reg == S_DIVV_W || state_reg == S_DIVD_W,
        "divider finished outside a wait state")

endmodule
